// ===== rtl/core/pwl_pkg.sv =====
package pwl_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned LevW   = 32;
  localparam int unsigned CfgW   = 7;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned FracW  = 16;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [SlotW-1:0] slot;
    logic [PosW-1:0]  position;
    logic [LevW-1:0]  level;
  } req_t;

endpackage

// ===== rtl/core/pwl_front.sv =====
module pwl_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  pwl_pkg::req_t in_req_i,
  output logic         in_ready_o,
  output logic         q_valid_o,
  output pwl_pkg::req_t q_req_o,
  input  logic         q_pop_i
);
  import pwl_pkg::*;

  // two-entry request queue between front and back
  req_t        mem_q [2];
  logic [1:0]  cnt_q, cnt_d;
  logic        wr_q, rd_q;
  logic        push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_req_o    = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !(q_pop_i && q_valid_o)) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i && q_valid_o) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (q_pop_i && q_valid_o) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_req_i;
    end
  end

endmodule

// ===== rtl/core/pwl_back.sv =====
module pwl_back #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [pwl_pkg::CfgW-1:0]  points_used_i,
  input  logic                      q_valid_i,
  input  pwl_pkg::req_t             q_req_i,
  output logic                      q_pop_o,
  output logic                      res_valid_o,
  output logic [pwl_pkg::LevW-1:0]  res_level_o,
  output logic                      res_oor_o,
  output logic                      busy_o
);
  import pwl_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = AW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD0   = 4'd1;
  localparam logic [3:0] S_CHK0  = 4'd2;
  localparam logic [3:0] S_CHKN  = 4'd3;
  localparam logic [3:0] S_SRCH  = 4'd4;
  localparam logic [3:0] S_SCMP  = 4'd5;
  localparam logic [3:0] S_RDB   = 4'd6;
  localparam logic [3:0] S_RDA   = 4'd7;
  localparam logic [3:0] S_PREP  = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_MUL   = 4'd10;
  localparam logic [3:0] S_ADD   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [PosW-1:0] pos_mem [TABLE_DEPTH];
  logic [LevW-1:0] lev_mem [TABLE_DEPTH];
  logic [AW-1:0]   raddr;
  logic [PosW-1:0] pos_rd_q;
  logic [LevW-1:0] lev_rd_q;

  logic [3:0]      state_q;
  logic [PosW-1:0] qpos_q;
  logic [NW-1:0]   n_q, lo_q, cnt_q, mid_q;
  logic [PosW-1:0] w2_q;
  logic [LevW-1:0] b_q, a_q;
  logic [PosW+FracW-1:0] rem_q;
  logic [FracW-1:0] t_q;
  logic [4:0]      dcnt_q;
  logic signed [LevW:0]     diff_q;
  logic signed [LevW+FracW+1:0] prod_q;
  logic [LevW-1:0] res_q;
  logic            oor_q, rv_q;

  logic [NW-1:0]   n_sat;
  logic [PosW:0]   den;
  logic [PosW+FracW:0] trial;
  logic [NW-1:0]   half;
  logic signed [LevW+1:0] fl;

  logic [NW-1:0] pu_ext;
  assign pu_ext = NW'(points_used_i);
  assign n_sat  = (32'(points_used_i) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : pu_ext;

  assign half  = cnt_q >> 1;
  assign den   = {1'b0, w2_q - pos_rd_q};
  assign trial = {rem_q, 1'b0} - {{(FracW){1'b0}}, den};
  assign fl    = (LevW+2)'(prod_q >>> FracW);

  assign busy_o      = (state_q != S_IDLE);
  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign res_valid_o = rv_q;
  assign res_level_o = res_q;
  assign res_oor_o   = oor_q;

  always_comb begin
    raddr = '0;
    case (state_q)
      S_CHK0:  raddr = AW'(n_q - NW'(1));
      S_SRCH:  raddr = AW'(mid_q);
      S_RDB:   raddr = AW'(lo_q);
      S_RDA:   raddr = AW'(lo_q - NW'(1));
      S_PREP:  raddr = AW'(lo_q - NW'(1));
      S_DIV:   raddr = AW'(lo_q - NW'(1));
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_req_i.cmd == CMD_LOAD && 32'(q_req_i.slot) < TABLE_DEPTH) begin
      pos_mem[AW'(q_req_i.slot)] <= q_req_i.position;
      lev_mem[AW'(q_req_i.slot)] <= q_req_i.level;
    end
    pos_rd_q <= pos_mem[raddr];
    lev_rd_q <= lev_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rv_q    <= 1'b0;
    end else begin
      rv_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_pop_o && q_req_i.cmd == CMD_QUERY) begin
            qpos_q <= q_req_i.position;
            n_q    <= n_sat;
            if (n_sat == '0) begin
              res_q   <= '0;
              oor_q   <= 1'b1;
              state_q <= S_OUT;
            end else begin
              state_q <= S_RD0;
            end
          end
        end
        S_RD0: state_q <= S_CHK0;
        S_CHK0: begin
          if (qpos_q < pos_rd_q) begin
            res_q <= '0; oor_q <= 1'b1; state_q <= S_OUT;
          end else begin
            state_q <= S_CHKN;
          end
        end
        S_CHKN: begin
          if (qpos_q > pos_rd_q) begin
            res_q <= '0; oor_q <= 1'b1; state_q <= S_OUT;
          end else begin
            lo_q    <= '0;
            cnt_q   <= n_q;
            mid_q   <= n_q >> 1;
            state_q <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (cnt_q == '0) begin
            state_q <= S_RDB;
          end else begin
            state_q <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (!(qpos_q < pos_rd_q)) begin
            lo_q  <= lo_q + half + NW'(1);
            cnt_q <= cnt_q - half - NW'(1);
            mid_q <= lo_q + half + NW'(1) + ((cnt_q - half - NW'(1)) >> 1);
          end else begin
            cnt_q <= half;
            mid_q <= lo_q + (half >> 1);
          end
          state_q <= S_SRCH;
        end
        S_RDB: begin
          oor_q <= 1'b0;
          if (lo_q == '0) begin
            state_q <= S_ADD;
            dcnt_q  <= '0;
          end else if (lo_q >= n_q) begin
            lo_q    <= n_q;
            state_q <= S_RDA;
          end else begin
            state_q <= S_RDA;
          end
        end
        S_RDA: begin
          w2_q    <= pos_rd_q;
          b_q     <= lev_rd_q;
          state_q <= S_PREP;
        end
        S_PREP: begin
          a_q  <= lev_rd_q;
          diff_q <= $signed({b_q[LevW-1], b_q}) - $signed({lev_rd_q[LevW-1], lev_rd_q});
          if (lo_q >= n_q || !(pos_rd_q <= qpos_q && qpos_q < w2_q)) begin
            t_q     <= '0;
            state_q <= S_MUL;
          end else begin
            rem_q   <= (PosW+FracW)'(qpos_q - pos_rd_q);
            t_q     <= '0;
            dcnt_q  <= 5'(FracW);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division: (q-w1)/(w2-w1) is below one, one fraction bit a step
          if (!trial[PosW+FracW]) begin
            rem_q <= trial[PosW+FracW-1:0];
            t_q   <= {t_q[FracW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[PosW+FracW-2:0], 1'b0};
            t_q   <= {t_q[FracW-2:0], 1'b0};
          end
          dcnt_q <= dcnt_q - 5'd1;
          if (dcnt_q == 5'd1) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= diff_q * $signed({1'b0, t_q});
          dcnt_q  <= 5'd1;
          state_q <= S_ADD;
        end
        S_ADD: begin
          if (dcnt_q == '0) begin
            res_q <= lev_rd_q;
          end else begin
            res_q <= a_q + LevW'(fl);
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          rv_q    <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/piecewise_linear_table_interp_top.sv =====
// channel | direction | handshake          | payload
// request | in        | start & !busy      | cmd_i slot_i position_i level_i
// result  | out       | done_o strobe      | result_level_o out_of_range_o
// config  | in        | cfg_valid_i & cfg_ready_o | cfg_data_i (points_used)
// a load is written to the table when the back end pops it; the back end stays idle
// a query holds the back end through bound checks, serial binary search on the registered
// table read, 16 divider steps (skipped at the last point), multiply and add, then a result
// strobe; an empty table or a position below the first or above the last point skips the rest
// reset clears control state only; table contents are undefined until loaded
// a two-entry queue takes requests while the back end works; busy is the queue full,
// results are strobed for one cycle and cannot be stalled
module piecewise_linear_table_interp_top #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      cmd_i,
  input  logic [pwl_pkg::SlotW-1:0] slot_i,
  input  logic [pwl_pkg::PosW-1:0]  position_i,
  input  logic signed [pwl_pkg::LevW-1:0] level_i,
  output logic                      done_o,
  output logic signed [pwl_pkg::LevW-1:0] result_level_o,
  output logic                      out_of_range_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [pwl_pkg::CfgW-1:0]  cfg_data_i
);
  import pwl_pkg::*;

  req_t            in_req, q_req;
  logic            in_ready, q_valid, q_pop, back_busy;
  logic [CfgW-1:0] points_used_q;
  logic [LevW-1:0] res_level;

  assign in_req.cmd      = cmd_e'(cmd_i);
  assign in_req.slot     = slot_i;
  assign in_req.position = position_i;
  assign in_req.level    = level_i;
  assign busy            = !in_ready;
  assign cfg_ready_o     = 1'b1;
  assign result_level_o  = $signed(res_level);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_used_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      points_used_q <= cfg_data_i;
    end
  end

  pwl_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(start), .in_req_i(in_req), .in_ready_o(in_ready),
    .q_valid_o(q_valid), .q_req_o(q_req), .q_pop_i(q_pop)
  );

  pwl_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .points_used_i(points_used_q),
    .q_valid_i(q_valid), .q_req_i(q_req), .q_pop_o(q_pop),
    .res_valid_o(done_o), .res_level_o(res_level), .res_oor_o(out_of_range_o),
    .busy_o(back_busy)
  );

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_of_range_o |-> res_level == '0) else $error("oor result not zero");
  a_done_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(back_busy)) else $error("result without work");

endmodule
